// ----- rtl/dti_pkg.sv -----
// shared constants and types for the decimal text to integer converter
package dti_pkg;

    localparam int CHAR_BITS = 8;
    localparam int OUT_BITS  = 32;

    // parse phase codes
    localparam logic [1:0] PH_START      = 2'd0;
    localparam logic [1:0] PH_LEAD       = 2'd1;
    localparam logic [1:0] PH_AFTER_SIGN = 2'd2;
    localparam logic [1:0] PH_DIGITS     = 2'd3;

    // character codes
    localparam logic [CHAR_BITS-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_BITS-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_BITS-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_BITS-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_BITS-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_BITS-1:0] CH_NINE  = 8'h39;

    typedef struct packed {
        logic [1:0] phase;
        logic       negative;
        logic       failed;
        logic       signed_mode;
    } t_parse_state;

endpackage

// ----- rtl/dti_step.sv -----
// one character step of the parser: phase update and multiply-by-ten accumulate
module dti_step #(
    parameter int VALUE_BITS = 32
) (
    input  dti_pkg::t_parse_state             i_state,
    input  logic [VALUE_BITS-1:0]             i_acc,
    input  logic [dti_pkg::CHAR_BITS-1:0]     i_char,
    input  logic                              i_no_char,
    input  logic                              i_want_signed,
    output dti_pkg::t_parse_state             o_state,
    output logic [VALUE_BITS-1:0]             o_acc
);
    import dti_pkg::*;

    localparam int SUM_BITS = VALUE_BITS + 4;

    t_parse_state            st;
    logic [VALUE_BITS-1:0]   acc;
    logic                    is_blank;
    logic                    is_digit;
    logic                    is_sign;
    logic                    take_digit;
    logic [3:0]              digit;
    logic [SUM_BITS-1:0]     wide_acc;
    logic [SUM_BITS-1:0]     sum;
    logic [SUM_BITS-1:0]     limit;

    always_comb begin
        st  = i_state;
        acc = i_acc;
        // first word of a string latches the mode and clears the rest
        if (st.phase == PH_START) begin
            st.signed_mode = i_want_signed;
            st.negative    = 1'b0;
            st.failed      = 1'b0;
            st.phase       = PH_LEAD;
            acc            = '0;
        end

        is_blank = (i_char == CH_SPACE) || (i_char == CH_TAB);
        is_digit = (i_char >= CH_ZERO) && (i_char <= CH_NINE);
        is_sign  = (i_char == CH_PLUS) || (i_char == CH_MINUS);
        digit    = i_char[3:0];

        // acc * 10 + d as two shifts and adds, checked exactly against the limit
        wide_acc = SUM_BITS'(acc);
        sum      = (wide_acc << 3) + (wide_acc << 1) + SUM_BITS'(digit);
        limit    = st.signed_mode ? SUM_BITS'({1'b0, {(VALUE_BITS-1){1'b1}}})
                                  : SUM_BITS'({VALUE_BITS{1'b1}});

        take_digit = 1'b0;
        if (!i_no_char && !st.failed) begin
            priority if (st.phase == PH_DIGITS) begin
                if (is_digit) begin
                    take_digit = 1'b1;
                end else begin
                    st.failed = 1'b1;
                end
            end else if (is_digit) begin
                st.phase   = PH_DIGITS;
                take_digit = 1'b1;
            end else if (is_blank) begin
                st.failed = st.failed;
            end else if (st.phase == PH_LEAD && st.signed_mode && is_sign) begin
                st.negative = (i_char == CH_MINUS);
                st.phase    = PH_AFTER_SIGN;
            end else begin
                st.failed = 1'b1;
            end
        end

        if (take_digit) begin
            if (sum <= limit) begin
                acc = sum[VALUE_BITS-1:0];
            end else begin
                st.failed = 1'b1;
            end
        end

        o_state = st;
        o_acc   = acc;
    end

endmodule

// ----- rtl/decimal_text_to_integer.sv -----
// decimal text to integer converter: top level with input and result registers
//
//  channel   | dir | tdata            | tuser                      | tlast
//  ----------+-----+------------------+----------------------------+-----------
//  s (chars) | in  | [7:0] char_code  | [0] no_char, [1] want_signed | is_last
//  m (result)| out | [31:0] value     | [0] ok                     | -
//
//  one character word is taken per cycle while o_s_tready is high; the last word of a
//  string is held in the input register, then its result in the result register
//  i_rst_n is synchronous, active low, and returns the parser to the start of a string
//  while i_m_tready is low the result holds; words without tlast keep flowing,
//  and a last word waits in the input register until the result register frees
module decimal_text_to_integer #(
    parameter int VALUE_BITS = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [dti_pkg::CHAR_BITS-1:0]   i_s_tdata,   // [7:0] char_code
    input  logic [1:0]                      i_s_tuser,   // [0] no_char, [1] want_signed
    input  logic                            i_s_tlast,   // is_last
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [dti_pkg::OUT_BITS-1:0]    o_m_tdata,   // [31:0] value
    output logic                            o_m_tuser    // [0] ok
);
    import dti_pkg::*;

    // input register
    logic                  r_in_valid;
    logic [CHAR_BITS-1:0]  r_in_char;
    logic                  r_in_no_char;
    logic                  r_in_signed;
    logic                  r_in_last;

    // parser state
    t_parse_state          r_st;
    logic [VALUE_BITS-1:0] r_acc;
    t_parse_state          n_st;
    logic [VALUE_BITS-1:0] n_acc;

    // result register
    logic                  r_out_valid;
    logic [OUT_BITS-1:0]   r_out_value;
    logic                  r_out_ok;

    logic                  s_take;
    logic                  advance;
    logic [VALUE_BITS-1:0] res_value;
    logic [63:0]           res_wide;

    assign advance    = r_in_valid && (!r_in_last || !r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;
    assign s_take     = i_s_tvalid && o_s_tready;

    dti_step #(
        .VALUE_BITS (VALUE_BITS)
    ) u_step (
        .i_state       (r_st),
        .i_acc         (r_acc),
        .i_char        (r_in_char),
        .i_no_char     (r_in_no_char),
        .i_want_signed (r_in_signed),
        .o_state       (n_st),
        .o_acc         (n_acc)
    );

    always_comb begin
        priority if (n_st.failed) begin
            res_value = '0;
        end else if (n_st.negative) begin
            res_value = '0 - n_acc;
        end else begin
            res_value = n_acc;
        end
        res_wide = 64'(res_value);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_take) begin
            r_in_char    <= i_s_tdata;
            r_in_no_char <= i_s_tuser[0];
            r_in_signed  <= i_s_tuser[1];
            r_in_last    <= i_s_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= '{phase: PH_START, negative: 1'b0, failed: 1'b0, signed_mode: 1'b0};
            r_acc <= '0;
        end else if (advance) begin
            if (r_in_last) begin
                r_st  <= '{phase: PH_START, negative: 1'b0, failed: 1'b0,
                           signed_mode: n_st.signed_mode};
                r_acc <= '0;
            end else begin
                r_st  <= n_st;
                r_acc <= n_acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_last) begin
            r_out_value <= res_wide[OUT_BITS-1:0];
            r_out_ok    <= !n_st.failed;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_value;
    assign o_m_tuser  = r_out_ok;

`ifndef NO_ASSERTIONS
    a_fail_gives_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tdata == '0)
        else $error("failed result carries a nonzero value");

    a_last_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in_last |=> r_st.phase == PH_START && r_acc == '0)
        else $error("parser not back at string start after a last word");

    a_start_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.phase == PH_START |-> !r_st.failed && !r_st.negative)
        else $error("flags set at string start");

    a_signed_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.signed_mode && r_st.phase != PH_START |-> !r_acc[VALUE_BITS-1])
        else $error("signed magnitude beyond range");

    a_result_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_m_tready |=> r_out_valid)
        else $error("stalled result dropped");
`endif

endmodule

// ----- bench/decimal_text_to_integer_tb.sv -----
// testbench for the decimal text to integer converter: directed and random strings checked against a parser
module decimal_text_to_integer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dti_pkg::*;

    localparam int LONG_HOLD    = 120;
    localparam int LIMIT_CYCLES = 200_000;

    typedef logic [7:0] t_char_q[$];

    typedef struct {
        logic [OUT_BITS-1:0] value;
        logic                ok;
    } t_number;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_s_tvalid;
    logic                 o_s_tready;
    logic [CHAR_BITS-1:0] i_s_tdata;   // [7:0] char_code
    logic [1:0]           i_s_tuser;   // [0] no_char, [1] want_signed
    logic                 i_s_tlast;   // is_last
    logic                 o_m_tvalid;
    logic                 i_m_tready;
    logic [OUT_BITS-1:0]  o_m_tdata;   // [31:0] value
    logic                 o_m_tuser;   // [0] ok

    // parser state mirrored on the testbench side
    logic [63:0] ps_acc;
    logic [1:0]  ps_phase;
    logic        ps_neg;
    logic        ps_failed;
    logic        ps_signed;

    t_number expected_numbers[$];
    int      words_sent    = 0;
    int      failures      = 0;
    int      cycle_count   = 0;
    int      hold_requests = 0;
    bit      tx_idle_en    = 1'b1;
    bit      rx_idle_en    = 1'b1;

    decimal_text_to_integer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic track_char(input logic [7:0] c, input logic nc, input logic last,
                              input logic ws);
        logic        blank;
        logic        digit;
        logic [63:0] lim;
        logic [63:0] d;
        t_number     r;
        if (ps_phase == PH_START) begin
            ps_signed = ws;
            ps_acc    = '0;
            ps_neg    = 1'b0;
            ps_failed = 1'b0;
            ps_phase  = PH_LEAD;
        end
        blank = (c == CH_SPACE) || (c == CH_TAB);
        digit = (c >= CH_ZERO) && (c <= CH_NINE);
        lim   = ps_signed ? 64'h7FFF_FFFF : 64'hFFFF_FFFF;
        d     = {56'b0, c} - {56'b0, CH_ZERO};
        if (!nc && !ps_failed) begin
            if (digit) begin
                ps_phase = PH_DIGITS;
                // exact overflow test before the multiply-add
                if (ps_acc > (lim - d) / 10)
                    ps_failed = 1'b1;
                else
                    ps_acc = ps_acc * 10 + d;
            end else if (ps_phase == PH_DIGITS || !blank) begin
                if (ps_phase == PH_LEAD && ps_signed && (c == CH_PLUS || c == CH_MINUS)) begin
                    ps_neg   = (c == CH_MINUS);
                    ps_phase = PH_AFTER_SIGN;
                end else begin
                    ps_failed = 1'b1;
                end
            end
        end
        if (last) begin
            if (ps_failed)
                r.value = '0;
            else if (ps_neg)
                r.value = -ps_acc[31:0];
            else
                r.value = ps_acc[31:0];
            r.ok = !ps_failed;
            expected_numbers.push_back(r);
            ps_acc    = '0;
            ps_phase  = PH_START;
            ps_neg    = 1'b0;
            ps_failed = 1'b0;
        end
    endtask

    task automatic send_char(input logic [7:0] c, input logic nc, input logic last,
                             input logic ws);
        if (tx_idle_en && $urandom_range(0, 3) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= c;
        i_s_tuser  <= {ws, nc};
        i_s_tlast  <= last;
        // ready is settled by the falling edge; the word goes in at the next rising edge
        @(negedge i_clk);
        while (!o_s_tready) @(negedge i_clk);
        @(posedge i_clk);
        track_char(c, nc, last, ws);
        if (!nc || last)
            words_sent++;
    endtask

    task automatic send_string(input t_char_q s, input logic sgn, input bit gaps);
        bit tail_nc;
        tail_nc = gaps && s.size() != 0 && $urandom_range(0, 9) == 0;
        if (s.size() == 0) begin
            send_char(8'($urandom), 1'b1, 1'b1, sgn);
        end else begin
            foreach (s[i]) begin
                if (gaps && $urandom_range(0, 19) == 0)
                    send_char(8'($urandom), 1'b1, 1'b0, (i == 0) ? sgn : 1'($urandom));
                send_char(s[i], 1'b0, !tail_nc && i == s.size() - 1,
                          (i == 0) ? sgn : 1'($urandom));
            end
            if (tail_nc)
                send_char(8'($urandom), 1'b1, 1'b1, 1'($urandom));
        end
    endtask

    function automatic t_char_q str_chars(string t);
        t_char_q q;
        for (int i = 0; i < t.len(); i++)
            q.push_back(8'(t[i]));
        return q;
    endfunction

    function automatic logic [7:0] stray_char();
        case ($urandom_range(0, 4))
            0: return CH_ZERO + 8'($urandom_range(0, 9));
            1: return $urandom_range(0, 1) ? CH_SPACE : CH_TAB;
            2: return $urandom_range(0, 1) ? CH_PLUS : CH_MINUS;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic make_random_text(output t_char_q s, output logic sgn);
        logic [63:0] n;
        logic [63:0] lim;
        t_char_q     digits;
        s   = {};
        sgn = 1'($urandom);
        lim = sgn ? 64'h7FFF_FFFF : 64'hFFFF_FFFF;
        if ($urandom_range(0, 19) == 0) begin
            // empty string
        end else if ($urandom_range(0, 9) < 2) begin
            repeat ($urandom_range(1, 6)) s.push_back(stray_char());
        end else begin
            repeat ($urandom_range(0, 2)) s.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
            if (sgn && $urandom_range(0, 1)) begin
                s.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
                repeat ($urandom_range(0, 1)) s.push_back(CH_SPACE);
            end
            if ($urandom_range(0, 14) != 0) begin
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 2)) s.push_back(CH_ZERO);
                case ($urandom_range(0, 5))
                    0: n = $urandom_range(0, 9);
                    1: n = $urandom_range(0, 99999);
                    2: n = {32'b0, $urandom};
                    3: n = lim - $urandom_range(0, 3);
                    4: n = lim + 1 + $urandom_range(0, 3);
                    default: n = {$urandom, $urandom} >> $urandom_range(20, 40);
                endcase
                do begin
                    digits.push_front(CH_ZERO + 8'(n % 10));
                    n = n / 10;
                end while (n != 0);
                s = {s, digits};
            end
            // a possibly broken sequence: one stray character anywhere
            if ($urandom_range(0, 9) == 0)
                s.insert($urandom_range(0, s.size()), stray_char());
        end
    endtask

    task automatic wait_results_drained();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (expected_numbers.size() != 0);
    endtask

    task automatic run_random_until(input int target);
        t_char_q s;
        logic    sgn;
        while (words_sent < target) begin
            make_random_text(s, sgn);
            send_string(s, sgn, 1'b1);
        end
    endtask

    task automatic test_directed_cases();
        t_char_q s;
        send_char(8'hFF, 1'b1, 1'b1, 1'b0);               // empty string
        send_string(str_chars("\t-"), 1'b1, 1'b0);        // blank then sign, no digits
        send_string(str_chars("4294967295"), 1'b0, 1'b0); // largest unsigned
        send_string(str_chars("12 "), 1'b0, 1'b0);        // trailing blank fails
        send_string(str_chars("+5"), 1'b0, 1'b0);         // no sign in unsigned mode
        s = {CH_ZERO + 8'd1, 8'h00, CH_ZERO + 8'd2};      // anything after a failure is ignored
        send_string(s, 1'b0, 1'b0);
        // no_char in the middle is skipped
        send_char(CH_ZERO + 8'd1, 1'b0, 1'b0, 1'b1);
        send_char(8'h00, 1'b1, 1'b0, 1'b0);
        send_char(CH_ZERO + 8'd2, 1'b0, 1'b1, 1'b0);
        // no_char with last closes the string
        send_char(CH_ZERO + 8'd3, 1'b0, 1'b0, 1'b0);
        send_char(8'hFF, 1'b1, 1'b1, 1'b1);
    endtask

    task automatic test_random_text();
        run_random_until(500);
    endtask

    task automatic test_drain_pause();
        t_char_q s;
        logic    sgn;
        repeat (15) begin
            make_random_text(s, sgn);
            send_string(s, sgn, 1'b1);
        end
        wait_results_drained();
        run_random_until(800);
    endtask

    task automatic test_backpressure();
        t_char_q s;
        tx_idle_en = 1'b0;
        hold_requests++;
        repeat (30) begin
            s = {CH_ZERO + 8'($urandom_range(0, 9))};
            send_string(s, 1'($urandom), 1'b0);
        end
        tx_idle_en = 1'b1;
    endtask

    task automatic test_steady_stream();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        run_random_until(1150);
    endtask

    // result side: random stalls, plus a long hold whenever one is requested
    initial begin : result_receiver
        int holds_served;
        holds_served = 0;
        i_m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (holds_served != hold_requests) begin
                holds_served++;
                i_m_tready <= 1'b0;
                repeat (LONG_HOLD - 1) @(posedge i_clk);
            end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(0, 2)) @(posedge i_clk);
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    always @(negedge i_clk) begin : result_check
        t_number want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_numbers.size() == 0) begin
                $error("result word with no string pending: value %0d ok %0b",
                       o_m_tdata, o_m_tuser);
                failures++;
            end else begin
                want = expected_numbers.pop_front();
                if (o_m_tdata !== want.value) begin
                    $error("value: expected %0d, got %0d", want.value, o_m_tdata);
                    failures++;
                end
                if (o_m_tuser !== want.ok) begin
                    $error("ok: expected %0b, got %0b", want.ok, o_m_tuser);
                    failures++;
                end
            end
        end
    end

    initial begin
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_s_tuser  <= '0;
        i_s_tlast  <= 1'b0;
        ps_acc    = '0;
        ps_phase  = PH_START;
        ps_neg    = 1'b0;
        ps_failed = 1'b0;
        ps_signed = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        test_random_text();
        test_drain_pause();
        test_backpressure();
        test_steady_stream();

        wait_results_drained();
        repeat (8) @(posedge i_clk);
        if (failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
